// ----- rtl/wpm_pkg.sv -----
package wpm_pkg;

  // Command codes of an incoming item
  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_TEXT    = 1'b1
  } cmd_e;

  // Input item as seen on the port
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // Result item as seen on the port
  typedef struct packed {
    logic matched;
    logic error;
  } out_item_t;

  // Classified item carried from the front part to the back part
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;      // folded to lower case
    logic       last;
    logic       is_any;  // folded byte is the run wildcard
    logic       is_one;  // folded byte is the single-byte wildcard
  } op_t;

  // Special pattern bytes and case folding
  localparam logic [7:0] CH_ONE      = 8'h3F;
  localparam logic [7:0] CH_ANY      = 8'h2A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Depth of the queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ----- rtl/wpm_front.sv -----
module wpm_front import wpm_pkg::*; (
  input  in_item_t in_item_i,
  output op_t      op_o
);

  logic [7:0] folded;

  // Fold ASCII upper case to lower case
  always_comb begin
    if (in_item_i.ch >= CH_UPPER_A && in_item_i.ch <= CH_UPPER_Z) begin
      folded = in_item_i.ch + CASE_OFFSET;
    end else begin
      folded = in_item_i.ch;
    end
  end

  // Classify the item for the back part
  assign op_o.cmd    = cmd_e'(in_item_i.cmd);
  assign op_o.ch     = folded;
  assign op_o.last   = in_item_i.last;
  assign op_o.is_any = (folded == CH_ANY);
  assign op_o.is_one = (folded == CH_ONE);

endmodule

// ----- rtl/wpm_queue.sv -----
module wpm_queue import wpm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> count_q != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue occupancy did not grow on push");

endmodule

// ----- rtl/wpm_back.sv -----
module wpm_back import wpm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  output logic      op_ready_o,
  input  op_t       op_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  // Pattern lanes
  logic [7:0]             pat_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] any_q, one_q;
  logic [MAX_PATTERN-1:0] valid_q, valid_d;
  logic [LEN_W-1:0]       len_q, len_d;
  // Position sets: lead is the closure of position zero alone
  logic [MAX_PATTERN:0]   lead_q, lead_d, active_q, active_d;
  logic                   start_q, start_d, ovf_q, ovf_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic                   pop, is_pat, is_text;
  logic [LEN_W-1:0]       len_base;
  logic [MAX_PATTERN-1:0] valid_base, wr_hit;
  logic [MAX_PATTERN:0]   lead_base, lead_app;
  logic                   full;

  logic [MAX_PATTERN-1:0] any_m, lane_ok;
  logic [MAX_PATTERN:0]   step_v, closed;
  logic [MAX_PATTERN:0]   add_x, add_y, add_s, carry;
  logic                   matched;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign pop        = op_valid_i && op_ready_o;
  assign is_pat     = pop && (op_i.cmd == CMD_PATTERN);
  assign is_text    = pop && (op_i.cmd == CMD_TEXT);

  // Pattern append: restart the pattern first when the previous one is finished
  always_comb begin
    len_base   = start_q ? '0 : len_q;
    valid_base = start_q ? '0 : valid_q;
    lead_base  = start_q ? (MAX_PATTERN+1)'(1) : lead_q;
    full       = (len_base == LEN_W'(MAX_PATTERN));
    lead_app   = lead_base;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      wr_hit[p]     = (len_base == LEN_W'(p));
      lead_app[p+1] = lead_base[p+1] | (wr_hit[p] & lead_base[p] & op_i.is_any);
    end
  end

  // Text step: advance every active lane by one byte
  always_comb begin
    any_m = any_q & valid_q;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      lane_ok[p] = one_q[p] | (pat_q[p] == op_i.ch);
    end
    step_v = {1'b0, active_q[MAX_PATTERN-1:0] & any_m}
           | {active_q[MAX_PATTERN-1:0] & valid_q & ~any_q & lane_ok, 1'b0};
    // Let runs of stars pass the set along, using the adder carry chain
    add_x   = {1'b0, any_m};
    add_y   = {1'b0, any_m & step_v[MAX_PATTERN-1:0]};
    add_s   = add_x + add_y;
    carry   = add_s ^ add_x ^ add_y;
    closed  = step_v | carry;
    matched = closed[len_q];
  end

  // Next state and result
  always_comb begin
    len_d       = len_q;
    valid_d     = valid_q;
    lead_d      = lead_q;
    active_d    = active_q;
    start_d     = start_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (is_pat) begin
      valid_d  = valid_base | wr_hit;
      lead_d   = lead_app;
      active_d = lead_app;
      len_d    = full ? len_base : len_base + 1'b1;
      ovf_d    = (start_q ? 1'b0 : ovf_q) | full;
      start_d  = op_i.last;
    end else if (is_text) begin
      start_d = 1'b1;
      if (op_i.last) begin
        active_d      = lead_q;
        out_valid_d   = 1'b1;
        out_d.matched = matched;
        out_d.error   = ovf_q;
      end else begin
        active_d = closed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      valid_q     <= '0;
      lead_q      <= (MAX_PATTERN+1)'(1);
      active_q    <= (MAX_PATTERN+1)'(1);
      start_q     <= 1'b1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      valid_q     <= valid_d;
      lead_q      <= lead_d;
      active_q    <= active_d;
      start_q     <= start_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Write the pattern byte into its lane; hold the result item
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if (is_pat && wr_hit[p]) begin
        pat_q[p] <= op_i.ch;
        any_q[p] <= op_i.is_any;
        one_q[p] <= op_i.is_one;
      end
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> len_q == LEN_W'(MAX_PATTERN))
    else $error("overflow flagged with pattern not full");

  a_len_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(len_q))
    else $error("valid lanes disagree with pattern length");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_text && op_i.last) |=> active_q == lead_q)
    else $error("active set not returned to start after result");

endmodule

// ----- rtl/wildcard_pattern_matcher_top.sv -----
// A text item ending a string passes the queue and then the output register before its result item appears.
// One item per cycle while the sink does not hold the output; the position update over all lanes is combinational.
// A two-entry queue parts front from back, and the output register parts back from the sink.
// Reset (rst_ni low, asynchronous) empties the pattern, the queue and the output register;
// the active set returns to position zero.
module wildcard_pattern_matcher_top import wpm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  op_t  front_op, queue_op;
  logic queue_valid, back_ready;

  // Fold and classify the incoming item
  wpm_front u_front (
    .in_item_i (in_item_i),
    .op_o      (front_op)
  );

  // Buffer classified items between the two parts
  wpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_op_i    (front_op),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_op_o     (queue_op)
  );

  // Store the pattern and advance the active set
  wpm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (queue_valid),
    .op_ready_o  (back_ready),
    .op_i        (queue_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- dv/wpm_checker.sv -----
module wpm_checker import wpm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_cnt_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MAX_PATTERN:0] LIVE_START = {{MAX_PATTERN{1'b0}}, 1'b1};

  // Own copy of the matcher state
  logic [7:0]           pat_mem [MAX_PATTERN];
  int unsigned          pat_len;
  logic [MAX_PATTERN:0] live;
  bit                   fresh_pat;
  bit                   pat_ovf;
  int                   fails;

  // Verdicts still owed by the block, oldest first
  out_item_t            verdict_q [$];

  // Fold upper-case ASCII letters to lower case
  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  // Let every live position sitting on a star also skip past it
  function automatic logic [MAX_PATTERN:0] skip_stars(input logic [MAX_PATTERN:0] s);
    for (int p = 0; p < pat_len; p++) begin
      if (s[p] && pat_mem[p] == CH_ANY) begin
        s[p+1] = 1'b1;
      end
    end
    return s;
  endfunction

  // Advance the glob state by one item; queue the verdict at the end of a text
  task automatic step_glob(input in_item_t it);
    logic [7:0]           c;
    logic [MAX_PATTERN:0] cur;
    logic [MAX_PATTERN:0] nxt;
    c = lower_case(it.ch);
    if (it.cmd == CMD_PATTERN) begin
      if (fresh_pat) begin
        pat_len   = 0;
        pat_ovf   = 1'b0;
        fresh_pat = 1'b0;
      end
      if (pat_len < MAX_PATTERN) begin
        pat_mem[pat_len] = c;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (it.last) begin
        fresh_pat = 1'b1;
      end
      live = LIVE_START;
    end else begin
      fresh_pat = 1'b1;
      cur = skip_stars(live);
      nxt = '0;
      for (int p = 0; p < pat_len; p++) begin
        if (cur[p]) begin
          if (pat_mem[p] == CH_ANY) begin
            nxt[p] = 1'b1;
          end else if (pat_mem[p] == CH_ONE || pat_mem[p] == c) begin
            nxt[p+1] = 1'b1;
          end
        end
      end
      if (!it.last) begin
        live = nxt;
      end else begin
        nxt = skip_stars(nxt);
        verdict_q.push_back('{matched: nxt[pat_len], error: pat_ovf});
        live = LIVE_START;
      end
    end
  endtask

  // Compare a result item with the oldest owed verdict
  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected result item: matched=%0b error=%0b", got.matched, got.error);
      fails++;
    end else begin
      want = verdict_q.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0b, actual %0b", want.matched, got.matched);
        fails++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0b, actual %0b", want.error, got.error);
        fails++;
      end
    end
  endtask

  // Watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len   = 0;
      pat_ovf   = 1'b0;
      fresh_pat = 1'b1;
      live      = LIVE_START;
      fails     = 0;
      verdict_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        step_glob(in_item_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_verdict(out_item_i);
      end
    end
    pending_o  <= verdict_q.size();
    fail_cnt_o <= fails;
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wpm_pkg::*;

  localparam int unsigned MAX_PATTERN = 64;
  localparam int unsigned RAND_ITEMS  = 800;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  int          fail_cnt;
  int          pending;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned hold_left = 0;
  logic        hold_req  = 1'b0;
  int unsigned cycles    = 0;

  logic [7:0] pat_bytes [$];
  logic [7:0] txt_bytes [$];

  wildcard_pattern_matcher_top #(
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  wpm_checker #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_i (out_item_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up when the run takes far too long
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sink: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_ready_i <= (hold_req || hold_left > 1) ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Offer one item, idling first at random; valid stays high after acceptance
  task automatic send_item(input cmd_e cmd, input logic [7:0] ch, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{cmd: cmd, ch: ch, last: last};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Send the pattern or text buffer, optionally marking its final byte
  task automatic send_run(input cmd_e cmd, input bit mark_last);
    int n;
    n = (cmd == CMD_PATTERN) ? pat_bytes.size() : txt_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_item(cmd, (cmd == CMD_PATTERN) ? pat_bytes[i] : txt_bytes[i],
                mark_last && i == n - 1);
    end
  endtask

  // Drop valid and hold until every owed verdict has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Flip the case of a letter at random
  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c | CASE_OFFSET) >= 8'h61 && (c | CASE_OFFSET) <= 8'h7A && $urandom_range(1) == 1)
      return c ^ CASE_OFFSET;
    return c;
  endfunction

  // One glob byte: mostly a few letters and wildcards, sometimes any byte
  function automatic logic [7:0] glob_byte();
    case ($urandom_range(9))
      0, 1, 2, 3: return flip_case(8'h61 + 8'($urandom_range(2)));
      4, 5:       return CH_ONE;
      6, 7:       return CH_ANY;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  // Build a fresh pattern, now and then one beyond capacity
  task automatic new_pattern();
    int n;
    n = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    pat_bytes.delete();
    repeat (n) pat_bytes.push_back(glob_byte());
  endtask

  // Build a text that fits the current pattern, sometimes spoiled
  task automatic new_text();
    txt_bytes.delete();
    foreach (pat_bytes[i]) begin
      if (pat_bytes[i] == CH_ONE) begin
        txt_bytes.push_back(8'($urandom_range(255)));
      end else if (pat_bytes[i] == CH_ANY) begin
        repeat ($urandom_range(3)) txt_bytes.push_back(glob_byte());
      end else begin
        txt_bytes.push_back(flip_case(pat_bytes[i]));
      end
    end
    if (txt_bytes.size() != 0 && $urandom_range(4) == 0) begin
      txt_bytes[$urandom_range(txt_bytes.size() - 1)] = 8'($urandom_range(255));
    end
    if ($urandom_range(9) == 0 || txt_bytes.size() == 0) begin
      txt_bytes.push_back(glob_byte());
    end
  endtask

  // One random sequence: mostly well formed, the rest broken or noise
  task automatic random_sequence();
    int kind;
    kind = $urandom_range(99);
    if (kind < 65) begin
      new_pattern();
      send_run(CMD_PATTERN, 1'b1);
      repeat ($urandom_range(1, 3)) begin
        new_text();
        send_run(CMD_TEXT, 1'b1);
      end
    end else if (kind < 75) begin
      // pattern left open, the text closes it
      new_pattern();
      send_run(CMD_PATTERN, 1'b0);
      new_text();
      send_run(CMD_TEXT, 1'b1);
    end else if (kind < 85) begin
      // text cut short by a new pattern
      new_text();
      send_run(CMD_TEXT, 1'b0);
      new_pattern();
      send_run(CMD_PATTERN, 1'b1);
      new_text();
      send_run(CMD_TEXT, 1'b1);
    end else if (kind < 92) begin
      new_text();
      send_run(CMD_TEXT, 1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_item(cmd_e'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Fill pattern or text buffer from a string
  task automatic load_str(input string s, input bit to_text);
    if (to_text) txt_bytes.delete();
    else pat_bytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      if (to_text) txt_bytes.push_back(s[i]);
      else pat_bytes.push_back(s[i]);
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Text with nothing stored: empty pattern never matches
    load_str("x", 1'b1);
    send_run(CMD_TEXT, 1'b1);
    // Plain match with both wildcards and mixed case
    load_str("A?c*", 1'b0);
    send_run(CMD_PATTERN, 1'b1);
    load_str("abCdd", 1'b1);
    send_run(CMD_TEXT, 1'b1);
    // Text abandoned by a pattern byte; open pattern closed by text
    load_str("ab", 1'b1);
    send_run(CMD_TEXT, 1'b0);
    load_str("Z", 1'b0);
    send_run(CMD_PATTERN, 1'b0);
    load_str("z", 1'b1);
    send_run(CMD_TEXT, 1'b1);
    // Extreme byte values
    pat_bytes = '{8'h00, 8'hFF};
    send_run(CMD_PATTERN, 1'b1);
    txt_bytes = '{8'h00, 8'hFF};
    send_run(CMD_TEXT, 1'b1);
    // Lone star
    load_str("*", 1'b0);
    send_run(CMD_PATTERN, 1'b1);
    txt_bytes = '{8'hFF};
    send_run(CMD_TEXT, 1'b1);
    load_str("Q", 1'b1);
    send_run(CMD_TEXT, 1'b1);
    // Pattern beyond capacity
    pat_bytes.delete();
    repeat (MAX_PATTERN + 2) pat_bytes.push_back(8'h61 + 8'($urandom_range(25)));
    send_run(CMD_PATTERN, 1'b1);
    new_text();
    send_run(CMD_TEXT, 1'b1);
    drain();

    // Hold the sink off while texts keep coming, so the block backs up
    in_valid_i <= 1'b0;
    hold_req   <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    load_str("a*", 1'b0);
    send_run(CMD_PATTERN, 1'b1);
    repeat (12) send_item(CMD_TEXT, glob_byte(), 1'b1);
    drain();

    // Random phases with different idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      goal = items_sent + RAND_ITEMS / 4;
      while (items_sent < goal) random_sequence();
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
